FILE: design/cti_pkg.sv
// ---------------------------------------------------------------------------
// cti_pkg: shared types for the calibration table interpolator
// Command codes, region codes, walker state codes and the front-to-back item record.
// ---------------------------------------------------------------------------
`default_nettype none
package cti_pkg;
  localparam int unsigned AngleW = 17;
  localparam int unsigned RotW   = 24;
  localparam int unsigned CntW   = 7;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_INTERP = 2'd0,
    REG_FIRST  = 2'd1,
    REG_LAST   = 2'd2,
    REG_NONE   = 2'd3
  } region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENDS,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // Query item as handed from the front to the back.
  typedef struct packed {
    logic signed [AngleW-1:0] angle;
  } query_t;
endpackage
`default_nettype wire

FILE: design/calibration_table_interpolator.sv
// ---------------------------------------------------------------------------
// calibration_table_interpolator: angle to rotation count lookup
// Piecewise-linear lookup over a loaded calibration table.
// ---------------------------------------------------------------------------
// A load item writes one angle/count pair and gives no result; it is held
// off (full high) while a query is queued or still in progress, so a
// query always sees the table as it was when the query was accepted.
// A query item gives one result: the first and last used entries are read,
// then the segments are checked one at a time through the single table read
// port, and a hit on a sloped segment goes through a multiply state plus a
// 43-step restoring divide. Queries wait in a 2-deep queue in front of the
// walker; the result sits in an output register, so a new query starts
// while the previous result waits to be popped.
`default_nettype none
module calibration_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                command_i,
  input  logic [5:0]          entry_index_i,
  input  logic signed [16:0]  entry_angle_i,
  input  logic signed [23:0]  entry_rotations_i,
  input  logic signed [16:0]  query_angle_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [23:0]  target_rotations_o,
  output logic [1:0]          region_o
);
  import cti_pkg::*;
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [6:0]          n_q;
  logic                wr_en, q_valid, q_take, busy;
  logic [IdxW-1:0]     wr_idx;
  logic signed [16:0]  wr_angle;
  logic signed [23:0]  wr_rot;
  query_t              q_item;

  // entries_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= 7'd64;
    else if (cfg_we_i) n_q <= cfg_wdata_i;
  end

  cti_front #(.Depth(TABLE_DEPTH), .IdxW(IdxW), .QDepth(2)) u_front (
    .clk_i, .rst_ni, .push, .full, .command_i, .entry_index_i,
    .entry_angle_i, .entry_rotations_i, .query_angle_i,
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_angle_o(wr_angle),
    .wr_rot_o(wr_rot), .q_valid_o(q_valid), .q_item_o(q_item),
    .q_take_i(q_take), .busy_i(busy)
  );

  cti_back #(.Depth(TABLE_DEPTH), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni, .n_i(n_q), .wr_en_i(wr_en), .wr_idx_i(wr_idx),
    .wr_angle_i(wr_angle), .wr_rot_i(wr_rot), .q_valid_i(q_valid),
    .q_item_i(q_item), .q_take_o(q_take), .busy_o(busy), .empty, .pop,
    .target_rotations_o, .region_o
  );
endmodule
`default_nettype wire

FILE: design/cti_front.sv
// ---------------------------------------------------------------------------
// cti_front: item intake
// Loads go straight to the table write port; queries enter a small queue.
// ---------------------------------------------------------------------------
`default_nettype none
module cti_front #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW = 6,
  parameter int unsigned QDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic [5:0]                   entry_index_i,
  input  logic signed [16:0]           entry_angle_i,
  input  logic signed [23:0]           entry_rotations_i,
  input  logic signed [16:0]           query_angle_i,
  output logic                         wr_en_o,
  output logic [IdxW-1:0]              wr_idx_o,
  output logic signed [16:0]           wr_angle_o,
  output logic signed [23:0]           wr_rot_o,
  output logic                         q_valid_o,
  output cti_pkg::query_t              q_item_o,
  input  logic                         q_take_i,
  input  logic                         busy_i
);
  import cti_pkg::*;
  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;

  query_t        fifo_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          acc, is_q, in_rng;

  // a query waits while the queue is full; a load waits until no query is queued or in progress
  assign full   = (cnt_q == (PW+1)'(QDepth)) || (!is_q && (q_valid_o || busy_i));
  assign acc    = push && !full;
  assign is_q   = (cmd_e'(command_i) == CMD_QUERY);
  assign in_rng = ({{(32-6){1'b0}}, entry_index_i} < 32'(Depth));

  assign wr_en_o    = acc && !is_q && in_rng;
  assign wr_idx_o   = IdxW'(entry_index_i);
  assign wr_angle_o = entry_angle_i;
  assign wr_rot_o   = entry_rotations_i;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc && is_q) begin
      fifo_q[wp_q].angle <= query_angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (acc && is_q) begin
        wp_q <= (wp_q == PW'(QDepth-1)) ? '0 : wp_q + 1'b1;
      end
      if (q_take_i && q_valid_o) begin
        rp_q <= (rp_q == PW'(QDepth-1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(acc && is_q) - (PW+1)'(q_take_i && q_valid_o);
    end
  end
endmodule
`default_nettype wire

FILE: design/cti_back.sv
// ---------------------------------------------------------------------------
// cti_back: table storage, segment walk, serial divide, result register
// ---------------------------------------------------------------------------
`default_nettype none
module cti_back #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [6:0]             n_i,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic signed [16:0]     wr_angle_i,
  input  logic signed [23:0]     wr_rot_i,
  input  logic                   q_valid_i,
  input  cti_pkg::query_t        q_item_i,
  output logic                   q_take_o,
  output logic                   busy_o,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [23:0]     target_rotations_o,
  output logic [1:0]             region_o
);
  import cti_pkg::*;
  localparam int unsigned NumW = 43;  // |q-a0|*|r1-r0| < 2^18 * 2^25
  localparam int unsigned DenW = 18;

  logic signed [16:0] ang_mem [Depth];
  logic signed [23:0] rot_mem [Depth];
  logic signed [16:0] ra_q;
  logic signed [23:0] rr_q;
  logic [IdxW-1:0]    raddr;

  state_e state_q, state_d;
  logic [IdxW:0]  cnt_q, last_q;   // read index / last slot
  logic [1:0]     sub_q;           // read phase within ENDS/WALK
  logic signed [16:0] qa_q, first_q, a0_q;
  logic signed [23:0] r0_q, lastr_q, firstr_q;
  logic           rise_q;
  logic signed [17:0] dq_q, den_q;
  logic signed [24:0] dr_q;
  logic [NumW-1:0]    num_q;
  logic [DenW:0]      rem_q;
  logic [5:0]         bit_q;
  logic               neg_q;
  logic signed [25:0] res_q;
  logic [1:0]         reg_q;
  logic               out_v_q;
  logic signed [23:0] out_r_q;
  logic [1:0]         out_g_q;

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ang_mem[wr_idx_i] <= wr_angle_i;
      rot_mem[wr_idx_i] <= wr_rot_i;
    end
    ra_q <= ang_mem[raddr];
    rr_q <= rot_mem[raddr];
  end

  logic [IdxW:0] n_cl;
  always_comb begin
    if (n_i < 7'd2) n_cl = (IdxW+1)'(2);
    else if ({25'd0, n_i} > 32'(Depth)) n_cl = (IdxW+1)'(Depth);
    else n_cl = (IdxW+1)'(n_i);
  end

  logic seg_done, hit, flat;
  assign raddr = cnt_q[IdxW-1:0];
  assign hit = rise_q ? (qa_q >= a0_q && qa_q <= ra_q)
                      : (qa_q <= a0_q && qa_q >= ra_q);
  assign flat = (ra_q == a0_q);
  assign seg_done = (cnt_q == last_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_ENDS;
      ST_ENDS: if (sub_q == 2'd2) state_d = ST_WALK;
      ST_WALK: begin
        if (sub_q == 2'd1) begin
          if (reg_q != REG_NONE) state_d = ST_DONE;
          else if (hit && !flat) state_d = ST_MUL;
          else if (hit || seg_done) state_d = ST_DONE;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (bit_q == '0) state_d = ST_DONE;
      ST_DONE: if (!out_v_q || pop) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign q_take_o = (state_q == ST_IDLE) && q_valid_i;
  assign busy_o = (state_q != ST_IDLE);
  assign empty = !out_v_q;
  assign target_rotations_o = out_r_q;
  assign region_o = out_g_q;

  logic [DenW:0] trial;
  assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};

  // magnitudes fit in 17 and 25 bits: a 17x25 product
  logic [17:0] dq_abs;
  logic [24:0] dr_abs;
  logic [41:0] prod;
  assign dq_abs = dq_q[17] ? -dq_q : dq_q;
  assign dr_abs = dr_q[24] ? -dr_q : dr_q;
  assign prod = {25'd0, dq_abs[16:0]} * {17'd0, dr_abs};

  logic signed [25:0] sum;
  logic [NumW-1:0] qmag;
  assign qmag = num_q;  // quotient accumulates into num_q low bits
  assign sum = 26'(r0_q) + (neg_q ? -26'(qmag) : 26'(qmag));

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        qa_q <= q_item_i.angle;
        cnt_q <= '0;
        last_q <= n_cl - 1'b1;
        sub_q <= '0;
        reg_q <= REG_NONE;
      end
      ST_ENDS: begin
        sub_q <= sub_q + 1'b1;
        if (sub_q == 2'd0) cnt_q <= last_q;
        if (sub_q == 2'd1) begin
          first_q <= ra_q; firstr_q <= rr_q; cnt_q <= '0;
        end
        if (sub_q == 2'd2) begin
          lastr_q <= rr_q; cnt_q <= (IdxW+1)'(1);
          a0_q <= first_q; r0_q <= firstr_q;
          rise_q <= (ra_q >= first_q);
          sub_q <= '0;
          if ((ra_q >= first_q) ? (qa_q <= first_q) : (qa_q >= first_q)) begin
            reg_q <= REG_FIRST; res_q <= 26'(firstr_q);
          end else if ((ra_q >= first_q) ? (qa_q >= ra_q) : (qa_q <= ra_q)) begin
            reg_q <= REG_LAST; res_q <= 26'(rr_q);
          end else begin
            res_q <= 26'(rr_q);
          end
        end
      end
      ST_WALK: begin
        // sub 0: read issued for cnt; sub 1: compare segment (a0, ra)
        if (sub_q == 2'd0) sub_q <= 2'd1;
        else if (reg_q == REG_NONE) begin
          sub_q <= '0;
          if (hit) begin
            reg_q <= REG_INTERP;
            res_q <= 26'(r0_q);
            dq_q  <= 18'(qa_q) - 18'(a0_q);
            den_q <= 18'(ra_q) - 18'(a0_q);
            dr_q  <= 25'(rr_q) - 25'(r0_q);
          end else begin
            a0_q <= ra_q; r0_q <= rr_q;
            cnt_q <= cnt_q + 1'b1;
            res_q <= 26'(lastr_q);
          end
        end
      end
      ST_MUL: begin
        num_q <= NumW'(prod);
        neg_q <= dq_q[17] ^ dr_q[24] ^ den_q[17];
        den_q <= den_q[17] ? -den_q : den_q;
        rem_q <= '0;
        bit_q <= 6'(NumW);
      end
      ST_DIV: begin
        // restoring divide; final step rounds half away from zero
        if (bit_q != '0) begin
          bit_q <= bit_q - 1'b1;
          if (trial >= {1'b0, den_q}) begin
            rem_q <= trial - {1'b0, den_q};
            num_q <= {num_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            num_q <= {num_q[NumW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (state_q == ST_DIV && bit_q == '0) begin
      res_q <= sum + 26'({rem_q, 1'b0} >= {2'b00, den_q} ? (neg_q ? -1 : 1) : 0);
    end
    if (state_q == ST_DONE && (!out_v_q || pop)) begin
      out_g_q <= reg_q;
      out_r_q <= (res_q > 26'sd8388607) ? 24'sh7fffff :
                 (res_q < -26'sd8388608) ? 24'sh800000 : res_q[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!out_v_q || pop)) out_v_q <= 1'b1;
      else if (pop && out_v_q) out_v_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire
